### src/i2crs_pkg.sv
`default_nettype none
package i2crs_pkg;

  // Largest number of bytes packed into one read word
  localparam int unsigned WORD_BYTES = 4;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned WORD_W     = WORD_BYTES * BYTE_W;
  localparam int unsigned COUNT_W    = 3;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned ADDR_W     = 7;
  localparam int unsigned EVENT_W    = 32;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_DATA_W = 80;

  // Event codes
  localparam logic [OP_W-1:0] OP_START     = 3'd0;
  localparam logic [OP_W-1:0] OP_ACK       = 3'd1;
  localparam logic [OP_W-1:0] OP_NACK      = 3'd2;
  localparam logic [OP_W-1:0] OP_STOP_DONE = 3'd3;
  localparam logic [OP_W-1:0] OP_RX_BYTE   = 3'd4;

  // Sequencer phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_SENT_ADDR = 3'd1;
  localparam logic [PHASE_W-1:0] PH_SENT_REG  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_WAIT_READ = 3'd3;
  localparam logic [PHASE_W-1:0] PH_RECEIVE   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_STOP      = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ADDRESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGISTER_COMMAND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_COUNT       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DONE_EVENT_ID    = 2'd3;

  localparam logic [COUNT_W-1:0] BYTE_COUNT_RESET = 3'd2;

  typedef struct packed {
    logic [ADDR_W-1:0]  device_address;
    logic [BYTE_W-1:0]  register_command;
    logic [COUNT_W-1:0] byte_count;
    logic [EVENT_W-1:0] done_event_id;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [COUNT_W-1:0] bytes_left;
    logic [WORD_W-1:0]  word_accumulator;
  } seq_state_t;

  typedef struct packed {
    logic               fault;
    logic [EVENT_W-1:0] done_event;
    logic               finished;
    logic [WORD_W-1:0]  read_word;
    logic               word_valid;
    logic               issue_nack_stop;
    logic               issue_ack;
    logic [BYTE_W-1:0]  tx_byte;
    logic               tx_valid;
    logic               issue_start;
  } result_t;

endpackage
`default_nettype wire

### src/i2crs_cfg_regs.sv
`default_nettype none
module i2crs_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_we,
  input  wire logic [i2crs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [i2crs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output i2crs_pkg::cfg_t                         cfg
);

  // Decode the index and hold the written value
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address   <= '0;
      cfg.register_command <= '0;
      cfg.byte_count       <= i2crs_pkg::BYTE_COUNT_RESET;
      cfg.done_event_id    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2crs_pkg::CFG_DEVICE_ADDRESS:
          cfg.device_address <= cfg_data[i2crs_pkg::ADDR_W-1:0];
        i2crs_pkg::CFG_REGISTER_COMMAND:
          cfg.register_command <= cfg_data[i2crs_pkg::BYTE_W-1:0];
        i2crs_pkg::CFG_BYTE_COUNT:
          cfg.byte_count <= cfg_data[i2crs_pkg::COUNT_W-1:0];
        i2crs_pkg::CFG_DONE_EVENT_ID:
          cfg.done_event_id <= cfg_data[i2crs_pkg::EVENT_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

### src/i2crs_step.sv
`default_nettype none
module i2crs_step (
  input  wire i2crs_pkg::cfg_t                  cfg,
  input  wire i2crs_pkg::seq_state_t            cur,
  input  wire logic [i2crs_pkg::OP_W-1:0]       operation,
  input  wire logic [i2crs_pkg::BYTE_W-1:0]     rx_byte,
  output i2crs_pkg::seq_state_t                 nxt,
  output i2crs_pkg::result_t                    res
);

  logic [i2crs_pkg::COUNT_W-1:0] start_count;
  logic [i2crs_pkg::COUNT_W-1:0] left_dec;
  logic [i2crs_pkg::WORD_W-1:0]  rx_placed;
  logic [i2crs_pkg::WORD_W-1:0]  acc_or;
  logic [i2crs_pkg::BYTE_W-1:0]  read_addr;
  logic                          bad;

  // Clamp the byte count into one to a full word
  always_comb begin
    if (cfg.byte_count == '0) begin
      start_count = i2crs_pkg::COUNT_W'(1);
    end else if (cfg.byte_count > i2crs_pkg::COUNT_W'(i2crs_pkg::WORD_BYTES)) begin
      start_count = i2crs_pkg::COUNT_W'(i2crs_pkg::WORD_BYTES);
    end else begin
      start_count = cfg.byte_count;
    end
  end

  // Place the received byte at its lane, first byte most significant
  always_comb begin
    left_dec  = (cur.bytes_left != '0) ? cur.bytes_left - 1'b1 : '0;
    rx_placed = i2crs_pkg::WORD_W'(rx_byte) << (i2crs_pkg::BYTE_W * left_dec[1:0]);
    acc_or    = cur.word_accumulator | rx_placed;
    read_addr = {cfg.device_address, 1'b1};
  end

  // Advance the phase for this event
  always_comb begin
    nxt = cur;
    res = '0;
    bad = 1'b0;
    unique case (operation)
      i2crs_pkg::OP_START: begin
        if (cur.phase == i2crs_pkg::PH_IDLE) begin
          nxt.bytes_left       = start_count;
          nxt.word_accumulator = '0;
          nxt.phase            = i2crs_pkg::PH_SENT_ADDR;
          res.issue_start      = 1'b1;
          res.tx_valid         = 1'b1;
          res.tx_byte          = {cfg.device_address, 1'b0};
        end else begin
          bad = 1'b1;
        end
      end
      i2crs_pkg::OP_ACK: begin
        if (cur.phase == i2crs_pkg::PH_SENT_ADDR) begin
          nxt.phase    = i2crs_pkg::PH_SENT_REG;
          res.tx_valid = 1'b1;
          res.tx_byte  = cfg.register_command;
        end else if (cur.phase == i2crs_pkg::PH_SENT_REG) begin
          nxt.phase       = i2crs_pkg::PH_WAIT_READ;
          res.issue_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = read_addr;
        end else if (cur.phase == i2crs_pkg::PH_WAIT_READ) begin
          nxt.phase = i2crs_pkg::PH_RECEIVE;
        end else begin
          bad = 1'b1;
        end
      end
      i2crs_pkg::OP_NACK: begin
        // Retry the repeated start with the read address
        if (cur.phase == i2crs_pkg::PH_WAIT_READ) begin
          res.issue_start = 1'b1;
          res.tx_valid    = 1'b1;
          res.tx_byte     = read_addr;
        end else begin
          bad = 1'b1;
        end
      end
      i2crs_pkg::OP_STOP_DONE: begin
        if (cur.phase == i2crs_pkg::PH_STOP) begin
          nxt.phase      = i2crs_pkg::PH_IDLE;
          res.finished   = 1'b1;
          res.done_event = cfg.done_event_id;
        end else begin
          bad = 1'b1;
        end
      end
      i2crs_pkg::OP_RX_BYTE: begin
        if (cur.phase == i2crs_pkg::PH_RECEIVE) begin
          nxt.bytes_left = left_dec;
          if (left_dec != '0) begin
            nxt.word_accumulator = acc_or;
            res.issue_ack        = 1'b1;
          end else begin
            nxt.word_accumulator = cur.word_accumulator
                                   | i2crs_pkg::WORD_W'(rx_byte);
            nxt.phase            = i2crs_pkg::PH_STOP;
            res.issue_nack_stop  = 1'b1;
            res.word_valid       = 1'b1;
            res.read_word        = cur.word_accumulator
                                   | i2crs_pkg::WORD_W'(rx_byte);
          end
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase

    // Drop everything but the fault flag on a disallowed event
    if (bad) begin
      nxt       = cur;
      res       = '0;
      res.fault = 1'b1;
    end
  end

endmodule
`default_nettype wire

### src/i2c_register_read_sequencer.sv
// The result word for an accepted event word is registered onto m_tdata in the cycle after acceptance.
// Throughput: one event per cycle; the single state update per event and the
// output register set the figure, and s_tready stays high while the output
// register is empty or being drained.
// Reset (rst, synchronous): phase idle, byte count and word cleared, output
// empty, configuration back to its defaults.
`default_nettype none
module i2c_register_read_sequencer (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // Configuration write port
  input  wire logic                                 cfg_we,
  input  wire logic [i2crs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [i2crs_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Event stream
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,  // [7:0] rx_byte
  input  wire logic [i2crs_pkg::OP_W-1:0]           s_tuser,  // [2:0] operation
  // Result stream
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [0] issue_start, [1] tx_valid, [9:2] tx_byte, [10] issue_ack,
  // [11] issue_nack_stop, [12] word_valid, [44:13] read_word,
  // [76:45] done_event, [77] fault, [79:78] zero
  output logic [i2crs_pkg::OUT_DATA_W-1:0]          m_tdata,
  output logic                                      m_tlast   // finished
);

  i2crs_pkg::cfg_t        cfg;
  i2crs_pkg::seq_state_t  state;
  i2crs_pkg::seq_state_t  state_next;
  i2crs_pkg::result_t     res;
  logic                   accept;

  i2crs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  i2crs_step u_step (
    .cfg       (cfg),
    .cur       (state),
    .operation (s_tuser),
    .rx_byte   (s_tdata),
    .nxt       (state_next),
    .res       (res)
  );

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  // Advance the sequencer state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase            <= i2crs_pkg::PH_IDLE;
      state.bytes_left       <= '0;
      state.word_accumulator <= '0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // Hold the result word until the downstream side takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {2'b00, res.fault, res.done_event, res.read_word, res.word_valid,
                  res.issue_nack_stop, res.issue_ack, res.tx_byte, res.tx_valid,
                  res.issue_start};
      m_tlast <= res.finished;
    end
  end

endmodule
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import i2crs_pkg::*;

  localparam int unsigned ITEM_TARGET = 1850;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned REPORT_MAX  = 10;

  // Operation codes that the block does not know
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] rx;
  } bus_event_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;   // [7:0] rx_byte
  logic [OP_W-1:0]       s_tuser = '0;   // [2:0] operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // [0] issue_start, [1] tx_valid, [9:2] tx_byte, [10] issue_ack,
  // [11] issue_nack_stop, [12] word_valid, [44:13] read_word,
  // [76:45] done_event, [77] fault, [79:78] zero
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tlast;        // finished

  i2c_register_read_sequencer dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  always #4ns clk = ~clk;

  // Shadow of the sequencer: registers and read state
  cfg_t               reg_shadow;
  logic [PHASE_W-1:0] read_phase = PH_IDLE;
  logic [COUNT_W-1:0] bytes_to_go = '0;
  logic [WORD_W-1:0]  assembled_word = '0;

  result_t     pending_responses[$];
  result_t     oldest_response;
  int unsigned events_accepted = 0;
  int unsigned responses_seen = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Sender burst control
  int unsigned burst_left = 0;
  bit          gaps_on = 1'b1;

  // Receiver stall control
  logic [15:0] ready_pattern = 16'hFFFF;
  logic [7:0]  pattern_step = '0;
  int unsigned hold_left = 0;
  int unsigned holds_requested = 0;
  int unsigned holds_served = 0;

  function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] n);
    if (n == '0) return COUNT_W'(1);
    if (n > COUNT_W'(WORD_BYTES)) return COUNT_W'(WORD_BYTES);
    return n;
  endfunction

  // Work out the response to one accepted bus event and queue it
  task automatic respond_to_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] rx);
    result_t resp;
    logic    refused;
    resp = '0;
    refused = 1'b0;
    case (op)
      OP_START: begin
        if (read_phase == PH_IDLE) begin
          bytes_to_go = clamp_count(reg_shadow.byte_count);
          assembled_word = '0;
          read_phase = PH_SENT_ADDR;
          resp.issue_start = 1'b1;
          resp.tx_valid = 1'b1;
          resp.tx_byte = {reg_shadow.device_address, 1'b0};
        end else refused = 1'b1;
      end
      OP_ACK: begin
        if (read_phase == PH_SENT_ADDR) begin
          read_phase = PH_SENT_REG;
          resp.tx_valid = 1'b1;
          resp.tx_byte = reg_shadow.register_command;
        end else if (read_phase == PH_SENT_REG) begin
          read_phase = PH_WAIT_READ;
          resp.issue_start = 1'b1;
          resp.tx_valid = 1'b1;
          resp.tx_byte = {reg_shadow.device_address, 1'b1};
        end else if (read_phase == PH_WAIT_READ) begin
          read_phase = PH_RECEIVE;
        end else refused = 1'b1;
      end
      OP_NACK: begin
        // retry the repeated start with the read address
        if (read_phase == PH_WAIT_READ) begin
          resp.issue_start = 1'b1;
          resp.tx_valid = 1'b1;
          resp.tx_byte = {reg_shadow.device_address, 1'b1};
        end else refused = 1'b1;
      end
      OP_STOP_DONE: begin
        if (read_phase == PH_STOP) begin
          read_phase = PH_IDLE;
          resp.finished = 1'b1;
          resp.done_event = reg_shadow.done_event_id;
        end else refused = 1'b1;
      end
      OP_RX_BYTE: begin
        if (read_phase == PH_RECEIVE) begin
          if (bytes_to_go != '0) bytes_to_go = bytes_to_go - 1'b1;
          if (bytes_to_go != '0) begin
            assembled_word |= WORD_W'(rx) << (BYTE_W * bytes_to_go[1:0]);
            resp.issue_ack = 1'b1;
          end else begin
            assembled_word |= WORD_W'(rx);
            read_phase = PH_STOP;
            resp.issue_nack_stop = 1'b1;
            resp.word_valid = 1'b1;
            resp.read_word = assembled_word;
          end
        end else refused = 1'b1;
      end
      default: refused = 1'b1;
    endcase
    if (refused) begin
      resp = '0;
      resp.fault = 1'b1;
    end
    pending_responses.push_back(resp);
  endtask

  // Offer one event word, with a random gap at the start of some bursts
  task automatic send_event(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] rx);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on && $urandom_range(0, 3) != 0) gap = $urandom_range(1, 6);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= rx;
    do @(posedge clk); while (!s_tready);
    respond_to_event(op, rx);
    events_accepted++;
  endtask

  // Stop offering and wait for every queued response
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_DEVICE_ADDRESS:   reg_shadow.device_address = value[ADDR_W-1:0];
      CFG_REGISTER_COMMAND: reg_shadow.register_command = value[BYTE_W-1:0];
      CFG_BYTE_COUNT:       reg_shadow.byte_count = value[COUNT_W-1:0];
      default:              reg_shadow.done_event_id = value;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Zero, the top of the range, or a full-width random value
  function automatic logic [CFG_DATA_W-1:0] pick_value(input logic [CFG_DATA_W-1:0] top);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return top;
      default: return $urandom;
    endcase
  endfunction

  task automatic shuffle_registers();
    if ($urandom_range(0, 1) != 0) write_reg(CFG_DEVICE_ADDRESS, pick_value(32'h7F));
    if ($urandom_range(0, 1) != 0) write_reg(CFG_REGISTER_COMMAND, pick_value(32'hFF));
    if ($urandom_range(0, 1) != 0) write_reg(CFG_BYTE_COUNT, pick_value(32'h7));
    if ($urandom_range(0, 1) != 0) write_reg(CFG_DONE_EVENT_ID, pick_value(32'hFFFFFFFF));
  endtask

  // One register read with random content, now and then disturbed or cut short
  task automatic run_register_read();
    bus_event_t  plan[$];
    int unsigned retries;
    int unsigned cut;
    // finish a read that an earlier cut left open
    while (read_phase != PH_IDLE) begin
      case (read_phase)
        PH_RECEIVE: send_event(OP_RX_BYTE, 8'($urandom));
        PH_STOP:    send_event(OP_STOP_DONE, 8'($urandom));
        default:    send_event(OP_ACK, 8'($urandom));
      endcase
    end
    plan.push_back('{OP_START, 8'($urandom)});
    plan.push_back('{OP_ACK, 8'($urandom)});
    plan.push_back('{OP_ACK, 8'($urandom)});
    retries = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (retries) plan.push_back('{OP_NACK, 8'($urandom)});
    plan.push_back('{OP_ACK, 8'($urandom)});
    repeat (clamp_count(reg_shadow.byte_count)) plan.push_back('{OP_RX_BYTE, 8'($urandom)});
    plan.push_back('{OP_STOP_DONE, 8'($urandom)});
    // stray event at a random point
    if ($urandom_range(0, 4) == 0)
      plan.insert($urandom_range(0, plan.size()), '{3'($urandom), 8'($urandom)});
    // drop the tail of the read
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, plan.size() - 1);
      while (plan.size() > cut) void'(plan.pop_back());
    end
    foreach (plan[i]) send_event(plan[i].op, plan[i].rx);
  endtask

  // Default registers, every refused event in turn, one read-address retry
  task automatic test_default_read();
    send_event(OP_SPARE_7, 8'h00);
    send_event(OP_STOP_DONE, 8'hFF);
    send_event(OP_START, 8'h00);
    send_event(OP_START, 8'hFF);
    send_event(OP_ACK, 8'h00);
    send_event(OP_NACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_RX_BYTE, 8'h33);
    send_event(OP_NACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_RX_BYTE, 8'hA5);
    send_event(OP_RX_BYTE, 8'h5A);
    send_event(OP_RX_BYTE, 8'hCC);
    send_event(OP_STOP_DONE, 8'h00);
    drain();
  endtask

  // Registers at their extremes, byte count above the word size
  task automatic test_extreme_read();
    write_reg(CFG_DEVICE_ADDRESS, 32'h7F);
    write_reg(CFG_REGISTER_COMMAND, 32'hFF);
    write_reg(CFG_BYTE_COUNT, 32'h7);
    write_reg(CFG_DONE_EVENT_ID, 32'hFFFFFFFF);
    send_event(OP_START, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    send_event(OP_ACK, 8'h00);
    repeat (WORD_BYTES) send_event(OP_RX_BYTE, 8'hFF);
    send_event(OP_SPARE_5, 8'h00);
    send_event(OP_SPARE_6, 8'hFF);
    send_event(OP_STOP_DONE, 8'h00);
    drain();
  endtask

  // Long receiver hold with the sender offering back to back
  task automatic test_back_pressure();
    gaps_on = 1'b0;
    holds_requested++;
    repeat (3) run_register_read();
    drain();
    gaps_on = 1'b1;
  endtask

  // Random reads, registers rewritten between phases, mid-read included
  task automatic test_random_reads();
    int unsigned reads_left;
    reads_left = 0;
    while (events_accepted < ITEM_TARGET) begin
      if (reads_left == 0) begin
        drain();
        shuffle_registers();
        reads_left = $urandom_range(4, 16);
      end
      reads_left--;
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, 4)) send_event(3'($urandom), 8'($urandom));
      run_register_read();
    end
  endtask

  task automatic finish_run();
    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("i2c_register_read_sequencer: match");
    end else begin
      $display("i2c_register_read_sequencer: mismatch");
    end
    $finish;
  endtask

  initial begin
    reg_shadow = '0;
    reg_shadow.byte_count = BYTE_COUNT_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_default_read();
    test_extreme_read();
    test_back_pressure();
    test_random_reads();
    finish_run();
  end

  // Receiver: rotating stall pattern, plus a long hold on request
  always @(negedge clk) begin
    pattern_step <= pattern_step + 8'd1;
    if (pattern_step == 8'hFF)
      ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
    if (holds_requested != holds_served) begin
      holds_served <= holds_requested;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ready_pattern[pattern_step[3:0]];
    end
  end

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("response %0d: %s expected %h got %h", responses_seen, name, want, got);
    end
  endfunction

  // Check each accepted result word against the oldest queued response
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("response %0d: result word with nothing outstanding", responses_seen);
      end else begin
        oldest_response = pending_responses.pop_front();
        compare_field("issue_start", 32'(oldest_response.issue_start), 32'(m_tdata[0]));
        compare_field("tx_valid", 32'(oldest_response.tx_valid), 32'(m_tdata[1]));
        compare_field("tx_byte", 32'(oldest_response.tx_byte), 32'(m_tdata[9:2]));
        compare_field("issue_ack", 32'(oldest_response.issue_ack), 32'(m_tdata[10]));
        compare_field("issue_nack_stop", 32'(oldest_response.issue_nack_stop),
                      32'(m_tdata[11]));
        compare_field("word_valid", 32'(oldest_response.word_valid), 32'(m_tdata[12]));
        compare_field("read_word", oldest_response.read_word, m_tdata[44:13]);
        compare_field("done_event", oldest_response.done_event, m_tdata[76:45]);
        compare_field("fault", 32'(oldest_response.fault), 32'(m_tdata[77]));
        compare_field("padding", 32'd0, 32'(m_tdata[79:78]));
        compare_field("finished", 32'(oldest_response.finished), 32'(m_tlast));
      end
      responses_seen++;
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("i2c_register_read_sequencer: mismatch");
      $finish;
    end
  end

endmodule
`default_nettype wire

### files.f
src/i2crs_pkg.sv
src/i2crs_cfg_regs.sv
src/i2crs_step.sv
src/i2c_register_read_sequencer.sv
test/tb_top.sv
